/* src/bchd_pkg.sv */
// ----------------------------------------------------------------------------
// Button click and hold decoder package
// Shared types, register indexes and reset values for the decoder core.
// ----------------------------------------------------------------------------
package bchd_pkg;

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned INDEX_W = 3;

    localparam logic [TIME_W-1:0]  ELAPSED_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

    // Register indexes on the configuration channel.
    localparam logic [INDEX_W-1:0] REG_DEBOUNCE_MS    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_HOLD_MS        = 3'd1;
    localparam logic [INDEX_W-1:0] REG_CLICK_GAP_MS   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_STEP_PERIOD_MS = 3'd3;
    localparam logic [INDEX_W-1:0] REG_PULL_TYPE      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_CONTACT_TYPE   = 3'd5;
    localparam logic [INDEX_W-1:0] REG_STEP_CLICKS    = 3'd6;

    localparam logic [TIME_W-1:0] DEBOUNCE_MS_RST    = 16'd60;
    localparam logic [TIME_W-1:0] HOLD_MS_RST        = 16'd500;
    localparam logic [TIME_W-1:0] CLICK_GAP_MS_RST   = 16'd500;
    localparam logic [TIME_W-1:0] STEP_PERIOD_MS_RST = 16'd400;

    typedef struct packed {
        logic [TIME_W-1:0]  debounce_ms;
        logic [TIME_W-1:0]  hold_ms;
        logic [TIME_W-1:0]  click_gap_ms;
        logic [TIME_W-1:0]  step_period_ms;
        logic               pull_type;
        logic               contact_type;
        logic [COUNT_W-1:0] step_clicks;
    } bchd_cfg_t;

    typedef struct packed {
        logic               debounce_armed;
        logic               press_accepted;
        logic               hold_active;
        logic               one_click_pending;
        logic               step_active;
        logic [TIME_W-1:0]  elapsed_ticks;
        logic [COUNT_W-1:0] click_counter;
        logic [COUNT_W-1:0] last_clicks;
        logic [COUNT_W-1:0] last_hold_clicks;
    } bchd_state_t;

    typedef struct packed {
        logic               step_event;
        logic [COUNT_W-1:0] hold_click_count;
        logic [COUNT_W-1:0] click_count;
        logic               clicks_ready;
        logic               holding;
        logic               hold_start_event;
        logic               single_click_event;
        logic               release_event;
        logic               press_event;
        logic               pressed_level;
    } bchd_result_t;

endpackage

/* src/bchd_tick_logic.sv */
// ----------------------------------------------------------------------------
// Button decoder tick logic
// Works out the next decoder state and the result word for one tick.
// ----------------------------------------------------------------------------
module bchd_tick_logic (
    input  logic                  pin_level,
    input  bchd_pkg::bchd_cfg_t   cfg,
    input  bchd_pkg::bchd_state_t state_cur,
    output bchd_pkg::bchd_state_t state_nxt,
    output bchd_pkg::bchd_result_t result
);
    import bchd_pkg::*;

    logic               pressed;
    logic               armed;
    logic               accepted;
    logic               hold;
    logic               pending;
    logic               stepping;
    logic [TIME_W-1:0]  elapsed;
    logic [COUNT_W-1:0] clicks;
    logic [COUNT_W-1:0] last_clicks;
    logic [COUNT_W-1:0] hold_clicks;
    logic               ev_press;
    logic               ev_release;
    logic               ev_single;
    logic               ev_hold;
    logic               ev_clicks;
    logic               ev_step;

    assign pressed = ~pin_level ^ cfg.pull_type ^ cfg.contact_type;

    // The stages follow one another in tick order; each sees the updates
    // made by the stages before it.
    always_comb begin
        armed       = state_cur.debounce_armed;
        accepted    = state_cur.press_accepted;
        hold        = state_cur.hold_active;
        pending     = state_cur.one_click_pending;
        stepping    = state_cur.step_active;
        clicks      = state_cur.click_counter;
        last_clicks = state_cur.last_clicks;
        hold_clicks = state_cur.last_hold_clicks;
        ev_press    = 1'b0;
        ev_release  = 1'b0;
        ev_single   = 1'b0;
        ev_hold     = 1'b0;
        ev_clicks   = 1'b0;
        ev_step     = 1'b0;

        if (state_cur.elapsed_ticks != ELAPSED_MAX) begin
            elapsed = state_cur.elapsed_ticks + 1'b1;
        end else begin
            elapsed = state_cur.elapsed_ticks;
        end

        // Press and debounce.
        if (pressed && !accepted) begin
            if (!armed) begin
                armed   = 1'b1;
                elapsed = '0;
            end else if (elapsed >= cfg.debounce_ms) begin
                accepted = 1'b1;
                ev_press = 1'b1;
                pending  = 1'b1;
            end
        end else begin
            armed = 1'b0;
        end

        // Release.
        if (!pressed && accepted) begin
            accepted = 1'b0;
            if (!hold && clicks != COUNT_MAX) begin
                clicks = clicks + 1'b1;
            end
            hold       = 1'b0;
            ev_release = 1'b1;
            elapsed    = '0;
            if (stepping) begin
                last_clicks = '0;
                clicks      = '0;
                stepping    = 1'b0;
            end
            if (pending) begin
                pending   = 1'b0;
                ev_single = 1'b1;
            end
        end

        // Hold start.
        if (accepted && pressed && !hold && elapsed >= cfg.hold_ms) begin
            hold        = 1'b1;
            hold_clicks = clicks;
            clicks      = '0;
            last_clicks = '0;
            ev_hold     = 1'b1;
            stepping    = 1'b1;
            pending     = 1'b0;
            elapsed     = '0;
        end

        // The click gap closes a series.
        if (elapsed >= cfg.click_gap_ms && clicks != '0) begin
            last_clicks = clicks;
            clicks      = '0;
            ev_clicks   = 1'b1;
        end

        // Step pulses while holding.
        if (hold_clicks == cfg.step_clicks && stepping && elapsed >= cfg.step_period_ms) begin
            elapsed = '0;
            ev_step = 1'b1;
        end
    end

    always_comb begin
        state_nxt.debounce_armed    = armed;
        state_nxt.press_accepted    = accepted;
        state_nxt.hold_active       = hold;
        state_nxt.one_click_pending = pending;
        state_nxt.step_active       = stepping;
        state_nxt.elapsed_ticks     = elapsed;
        state_nxt.click_counter     = clicks;
        state_nxt.last_clicks       = last_clicks;
        state_nxt.last_hold_clicks  = hold_clicks;

        result.pressed_level      = pressed;
        result.press_event        = ev_press;
        result.release_event      = ev_release;
        result.single_click_event = ev_single;
        result.hold_start_event   = ev_hold;
        result.holding            = hold;
        result.clicks_ready       = ev_clicks;
        result.click_count        = last_clicks;
        result.hold_click_count   = hold ? hold_clicks : '0;
        result.step_event         = ev_step;
    end

endmodule

/* src/button_click_hold_decoder_core.sv */
// ----------------------------------------------------------------------------
// Button click and hold decoder core
// Debounces a sampled button pin and decodes press, release, click series,
// hold and step events, one input word per millisecond tick.
// ----------------------------------------------------------------------------
// Each input word is one tick and yields exactly one result word. The core
// takes one word per clock while the result side is not stalled: the word is
// held in an input register, and when it moves on the decoder state and the
// result register are updated from it, so the result word is presented in
// the cycle after its word leaves the input register. A stall on the result
// side fills the input register and then drops s_axis_tready.
// Configuration writes are taken on every cycle and should only be issued
// while no tick is in flight.
module button_click_hold_decoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bchd_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [bchd_pkg::TIME_W-1:0]   cfg_data,
    // Input ticks.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [0] pin_level, [7:1] zero
    // Results.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] pressed_level, [1] press_event, [2] release_event,
    // [3] single_click_event, [4] hold_start_event, [5] holding,
    // [6] clicks_ready, [14:7] click_count, [22:15] hold_click_count,
    // [23] step_event
    output logic [23:0]                   m_axis_tdata
);
    import bchd_pkg::*;

    bchd_cfg_t    cfg_reg;
    bchd_state_t  state_reg;
    bchd_state_t  state_next;
    bchd_result_t result_next;
    bchd_result_t result_reg;
    logic         in_valid_reg;
    logic         in_pin_reg;
    logic         out_valid_reg;
    logic         advance;

    // A word moves on when the result register is empty or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms    <= DEBOUNCE_MS_RST;
            cfg_reg.hold_ms        <= HOLD_MS_RST;
            cfg_reg.click_gap_ms   <= CLICK_GAP_MS_RST;
            cfg_reg.step_period_ms <= STEP_PERIOD_MS_RST;
            cfg_reg.pull_type      <= 1'b0;
            cfg_reg.contact_type   <= 1'b0;
            cfg_reg.step_clicks    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE_MS:    cfg_reg.debounce_ms    <= cfg_data;
                REG_HOLD_MS:        cfg_reg.hold_ms        <= cfg_data;
                REG_CLICK_GAP_MS:   cfg_reg.click_gap_ms   <= cfg_data;
                REG_STEP_PERIOD_MS: cfg_reg.step_period_ms <= cfg_data;
                REG_PULL_TYPE:      cfg_reg.pull_type      <= cfg_data[0];
                REG_CONTACT_TYPE:   cfg_reg.contact_type   <= cfg_data[0];
                REG_STEP_CLICKS:    cfg_reg.step_clicks    <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_pin_reg <= s_axis_tdata[0];
        end
    end

    bchd_tick_logic u_tick (
        .pin_level (in_pin_reg),
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

`ifndef ASSERT_OFF
    a_hold_start_holding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && result_reg.hold_start_event |-> result_reg.holding)
        else $error("hold start without holding level");

    a_single_not_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && result_reg.single_click_event |-> !result_reg.hold_start_event)
        else $error("single click and hold start in one tick");

    a_step_needs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && result_reg.step_event |-> result_reg.holding)
        else $error("step pulse outside a hold");

    a_press_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && result_reg.press_event |-> result_reg.pressed_level)
        else $error("press accepted on a released level");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both registers are full and stalled");
`endif

endmodule
